@@ rtl/clen_pkg.sv @@
// types and constants shared by the content-length deframer modules
`default_nettype none

package clen_pkg;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_END   = 2'd1,
        OP_ERROR = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_LINE_LONG  = 3'd1,
        ERR_MANY_HDRS  = 3'd2,
        ERR_DUP_LENGTH = 3'd3,
        ERR_BAD_VALUE  = 3'd4,
        ERR_NO_LENGTH  = 3'd5,
        ERR_TRUNCATED  = 3'd6,
        ERR_STREAM     = 3'd7
    } err_t;

    typedef enum logic [2:0] {
        FS_PREFIX = 3'd0,
        FS_LEAD   = 3'd1,
        FS_DIGITS = 3'd2,
        FS_TRAIL  = 3'd3,
        FS_BAD    = 3'd4,
        FS_OTHER  = 3'd5
    } field_state_t;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_MAX_BODY    = 2'd0;
    localparam logic [1:0] REG_MAX_LINE    = 2'd1;
    localparam logic [1:0] REG_MAX_HEADERS = 2'd2;

    localparam logic [24:0] MAX_BODY_RESET    = 25'd16777216;
    localparam logic [20:0] MAX_LINE_RESET    = 21'd65536;
    localparam logic [7:0]  MAX_HEADERS_RESET = 8'd64;

    localparam logic [24:0] VALUE_MAX  = 25'h1FFFFFF;
    localparam logic [3:0]  PREFIX_LEN = 4'd15;

    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    typedef struct packed {
        logic [24:0] max_body;
        logic [20:0] max_line;
        logic [7:0]  max_headers;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  body_byte;
        logic        last;
        err_t        code;
    } result_t;

    // per-line parser state
    typedef struct packed {
        field_state_t fs;
        logic [3:0]   pos;
        logic [24:0]  acc;
        logic         big;
    } line_t;

endpackage

`default_nettype wire

@@ rtl/content_length_deframer.sv @@
// Content-Length deframer: strips header lines and passes the declared body bytes,
// reporting framing errors and empty messages. One word is taken every cycle unless
// the input stalls; each word waits in the input register while the framing logic
// judges it, and any result is then registered in the result register, from which
// the result word is offered. The input stalls only while the result register holds
// a word that the downstream side has not taken. Limits must be set through the apb
// port only while idle; the block itself does not enforce this.
`default_nettype none

module content_length_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] body_byte, [10:8] error_code, rest zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast
);
    import clen_pkg::*;

    cfg_t        cfg;
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_data_reg;
    logic        advance;
    logic        res_valid;
    result_t     res;
    logic        out_valid_reg;
    result_t     out_reg;

    clen_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    clen_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .opcode    (in_op_reg),
        .data      (in_data_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.code, out_reg.body_byte};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

@@ rtl/clen_cfg.sv @@
// apb register file for the deframer limits
`default_nettype none

module clen_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output clen_pkg::cfg_t     cfg
);
    import clen_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_body    <= MAX_BODY_RESET;
            cfg_reg.max_line    <= MAX_LINE_RESET;
            cfg_reg.max_headers <= MAX_HEADERS_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_MAX_BODY:    cfg_reg.max_body    <= pwdata[24:0];
                REG_MAX_LINE:    cfg_reg.max_line    <= pwdata[20:0];
                REG_MAX_HEADERS: cfg_reg.max_headers <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_BODY:    prdata = {7'd0, cfg_reg.max_body};
            REG_MAX_LINE:    prdata = {11'd0, cfg_reg.max_line};
            REG_MAX_HEADERS: prdata = {24'd0, cfg_reg.max_headers};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/clen_core.sv @@
// framing state and the per-word header/body decision logic
`default_nettype none

module clen_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [1:0]    opcode,
    input  wire logic [7:0]    data,
    input  wire clen_pkg::cfg_t cfg,
    output logic               res_valid,
    output clen_pkg::result_t  res
);
    import clen_pkg::*;

    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] c;
        begin
            case (pos)
                4'd0:    c = "c";
                4'd1:    c = "o";
                4'd2:    c = "n";
                4'd3:    c = "t";
                4'd4:    c = "e";
                4'd5:    c = "n";
                4'd6:    c = "t";
                4'd7:    c = "-";
                4'd8:    c = "l";
                4'd9:    c = "e";
                4'd10:   c = "n";
                4'd11:   c = "g";
                4'd12:   c = "t";
                4'd13:   c = "h";
                4'd14:   c = ":";
                default: c = 8'd0;
            endcase
            return c;
        end
    endfunction

    function automatic line_t parse_byte(input line_t l, input logic [7:0] c);
        line_t       r;
        logic [7:0]  low;
        logic        dig;
        logic        blank;
        logic [28:0] v;
        begin
            r     = l;
            low   = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
            dig   = (c >= "0") && (c <= "9");
            blank = (c == CHR_SPACE) || (c == CHR_TAB);
            // acc * 10 + digit, never above 29 bits
            v = ({4'd0, l.acc} << 3) + ({4'd0, l.acc} << 1) + {25'd0, c[3:0]};
            case (l.fs)
                FS_PREFIX:
                begin
                    if (l.pos < PREFIX_LEN && low == prefix_char(l.pos))
                    begin
                        r.pos = l.pos + 4'd1;
                        if (l.pos == PREFIX_LEN - 4'd1)
                            r.fs = FS_LEAD;
                    end
                    else
                        r.fs = FS_OTHER;
                end
                FS_LEAD, FS_DIGITS:
                begin
                    if (dig)
                    begin
                        r.fs = FS_DIGITS;
                        if (v > {4'd0, VALUE_MAX})
                        begin
                            r.big = 1'b1;
                            r.acc = VALUE_MAX;
                        end
                        else
                            r.acc = v[24:0];
                    end
                    else if (blank)
                        r.fs = (l.fs == FS_DIGITS) ? FS_TRAIL : FS_LEAD;
                    else
                        r.fs = FS_BAD;
                end
                FS_TRAIL:
                begin
                    if (!blank)
                        r.fs = FS_BAD;
                end
                default: ;
            endcase
            return r;
        end
    endfunction

    localparam line_t LINE_CLEAR = '{fs: FS_PREFIX, pos: 4'd0, acc: 25'd0, big: 1'b0};

    logic        in_body_reg,  in_body_next;
    logic [20:0] line_cnt_reg, line_cnt_next;
    logic [8:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic        seen_reg,     seen_next;
    logic [24:0] decl_reg,     decl_next;
    logic [24:0] left_reg,     left_next;
    line_t       line_reg,     line_next;
    logic        cr_reg,       cr_next;
    logic        begun_reg,    begun_next;

    line_t       line_cr;
    line_t       fin_src;
    logic [8:0]  hdr_inc;
    logic        fin_value;
    err_t        fin_err;
    logic        fin_declare;
    logic [21:0] line_inc;
    logic        clr_msg;
    logic        clr_line;

    assign line_cr  = cr_reg ? parse_byte(line_reg, CHR_CR) : line_reg;
    assign hdr_inc  = hdr_cnt_reg + 9'd1;
    assign line_inc = {1'b0, line_cnt_reg} + 22'd1;

    // judge a finished header line
    always_comb
    begin
        fin_src     = (opcode_t'(opcode) == OP_END) ? line_cr : line_reg;
        fin_value   = (fin_src.fs == FS_LEAD) || (fin_src.fs == FS_DIGITS)
                   || (fin_src.fs == FS_TRAIL) || (fin_src.fs == FS_BAD);
        fin_err     = ERR_NONE;
        fin_declare = 1'b0;
        if (hdr_inc > {1'b0, cfg.max_headers})
            fin_err = ERR_MANY_HDRS;
        else if (fin_value)
        begin
            if (seen_reg)
                fin_err = ERR_DUP_LENGTH;
            else if ((fin_src.fs != FS_DIGITS && fin_src.fs != FS_TRAIL) || fin_src.big
                     || fin_src.acc == 25'd0 || fin_src.acc > cfg.max_body)
                fin_err = ERR_BAD_VALUE;
            else
                fin_declare = 1'b1;
        end
    end

    always_comb
    begin
        in_body_next  = in_body_reg;
        line_cnt_next = line_cnt_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        seen_next     = seen_reg;
        decl_next     = decl_reg;
        left_next     = left_reg;
        line_next     = line_reg;
        cr_next       = cr_reg;
        begun_next    = begun_reg;
        clr_msg       = 1'b0;
        clr_line      = 1'b0;
        res_valid     = 1'b0;
        res           = '{kind: KIND_BODY, body_byte: 8'd0, last: 1'b0, code: ERR_NONE};

        case (opcode_t'(opcode))
            OP_DATA:
            begin
                begun_next = 1'b1;
                if (in_body_reg)
                begin
                    res_valid     = 1'b1;
                    res.body_byte = data;
                    res.last      = (left_reg <= 25'd1);
                    left_next     = (left_reg != 25'd0) ? left_reg - 25'd1 : left_reg;
                    clr_line      = 1'b1;
                    if (left_next == 25'd0)
                        clr_msg = 1'b1;
                end
                else if (data == CHR_LF)
                begin
                    if (line_cnt_reg == {20'd0, cr_reg})
                    begin
                        // blank line ends the header block
                        if (hdr_cnt_reg == 9'd0)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_NONE;
                            clr_msg   = 1'b1;
                        end
                        else if (!seen_reg)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_ERROR;
                            res.code  = ERR_NO_LENGTH;
                            clr_msg   = 1'b1;
                        end
                        else
                        begin
                            in_body_next = 1'b1;
                            left_next    = decl_reg;
                            clr_line     = 1'b1;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_inc;
                        clr_line     = 1'b1;
                        if (fin_err != ERR_NONE)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_ERROR;
                            res.code  = fin_err;
                            clr_msg   = 1'b1;
                        end
                        else if (fin_declare)
                        begin
                            decl_next = fin_src.acc;
                            seen_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    line_cnt_next = line_inc[20:0];
                    if (line_inc > {1'b0, cfg.max_line})
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_ERROR;
                        res.code  = ERR_LINE_LONG;
                        clr_msg   = 1'b1;
                    end
                    else if (data == CHR_CR)
                    begin
                        cr_next   = 1'b1;
                        line_next = line_cr;
                    end
                    else
                    begin
                        cr_next   = 1'b0;
                        line_next = parse_byte(line_cr, data);
                    end
                end
            end
            OP_END:
            begin
                res_valid = 1'b1;
                clr_msg   = 1'b1;
                res.kind  = KIND_ERROR;
                if (in_body_reg)
                    res.code = ERR_TRUNCATED;
                else if (!begun_reg)
                    res.kind = KIND_NONE;
                else if (line_cnt_reg != 21'd0)
                begin
                    // pending unterminated line counts as a header line
                    if (fin_err != ERR_NONE)
                        res.code = fin_err;
                    else if (seen_reg || fin_declare)
                        res.code = ERR_TRUNCATED;
                    else
                        res.code = ERR_NO_LENGTH;
                end
                else if (hdr_cnt_reg == 9'd0)
                    res.kind = KIND_NONE;
                else
                    res.code = seen_reg ? ERR_TRUNCATED : ERR_NO_LENGTH;
            end
            OP_ERROR:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
                res.code  = ERR_STREAM;
                clr_msg   = 1'b1;
            end
            default: ;
        endcase

        if (clr_line || clr_msg)
        begin
            line_cnt_next = 21'd0;
            line_next     = LINE_CLEAR;
            cr_next       = 1'b0;
        end
        if (clr_msg)
        begin
            in_body_next = 1'b0;
            hdr_cnt_next = 9'd0;
            seen_next    = 1'b0;
            decl_next    = 25'd0;
            left_next    = 25'd0;
            begun_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg  <= 1'b0;
            line_cnt_reg <= 21'd0;
            hdr_cnt_reg  <= 9'd0;
            seen_reg     <= 1'b0;
            decl_reg     <= 25'd0;
            left_reg     <= 25'd0;
            line_reg     <= LINE_CLEAR;
            cr_reg       <= 1'b0;
            begun_reg    <= 1'b0;
        end
        else if (step)
        begin
            in_body_reg  <= in_body_next;
            line_cnt_reg <= line_cnt_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            seen_reg     <= seen_next;
            decl_reg     <= decl_next;
            left_reg     <= left_next;
            line_reg     <= line_next;
            cr_reg       <= cr_next;
            begun_reg    <= begun_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/clen_checker.sv @@
// port-level checks for the content-length deframer, bound to the top level
`default_nettype none

module clen_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import clen_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // with the result register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // an error word carries a code, other words carry none
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_ERROR) == (m_tdata[10:8] != ERR_NONE)))
        else $error("error code does not match word kind");

    // reports carry no body byte and no last mark
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_BODY |-> m_tdata[7:0] == 8'd0 && !m_tlast)
        else $error("report word carries body data");

endmodule

bind content_length_deframer clen_checker u_clen_checker (.*);

`default_nettype wire
